// File: rtl/vrfh_pkg.sv
// ----------------------------------------------------------------------------
// vrfh_pkg: shared types and constants for the voxel first-hit ray caster
// Grid geometry, fixed-point format, face codes and the payload structs.
// ----------------------------------------------------------------------------
package vrfh_pkg;

    localparam int unsigned GRID_BITS  = 4;
    localparam int unsigned FRAC_BITS  = 8;
    localparam int unsigned COORD_W    = GRID_BITS + FRAC_BITS;
    localparam int unsigned INDEX_W    = 3 * GRID_BITS;
    localparam int unsigned CELL_COUNT = 1 << INDEX_W;

    localparam logic [2:0] ENTRY_TOP    = 3'd0;
    localparam logic [2:0] ENTRY_LEFT   = 3'd1;
    localparam logic [2:0] ENTRY_RIGHT  = 3'd2;
    localparam logic [2:0] ENTRY_BOTTOM = 3'd3;
    localparam logic [2:0] ENTRY_FRONT  = 3'd4;
    localparam logic [2:0] ENTRY_BACK   = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_z;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_z;
        logic [INDEX_W-1:0] cell_index;
        logic               cell_filled;
    } t_in_item;

    typedef struct packed {
        logic                 hit;
        logic [GRID_BITS-1:0] hit_x;
        logic [GRID_BITS-1:0] hit_y;
        logic [GRID_BITS-1:0] hit_z;
        logic [2:0]           entry_face;
    } t_out_item;

endpackage

// File: rtl/vrfh_if.sv
// ----------------------------------------------------------------------------
// vrfh_if: valid/ready channel carrying one payload per beat
// The payload type is chosen at instantiation.
// ----------------------------------------------------------------------------
interface vrfh_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/voxel_ray_first_hit.sv
// ----------------------------------------------------------------------------
// voxel_ray_first_hit: first occupied voxel along a ray
// i_in carries write beats (set or clear one cell of the 16x16x16 occupancy
// map) and cast beats (ray start and end, unsigned 4.8 fixed point).
// Every input beat yields exactly one beat on o_out: for a cast, the first
// solid cell met in 3D DDA order and the face it was entered by, else a miss;
// for a write, an all-zero beat.
// A write passes through a setup state and then loads the output register. A
// cast runs a setup state, then per visited cell a map read, a crossing-time
// compare and a step, and finally loads the output register. Its pace is set
// by the single read port of the map and the registered crossing-time compares.
// The block holds one item at a time; the next beat is taken once the
// previous result sits in the output register. While the receiver stalls,
// that result is held and a finished item waits before the output register.
// After reset the map is swept clear, one cell a cycle through all 4096 cells,
// during which no input beat is accepted.
// ----------------------------------------------------------------------------
module voxel_ray_first_hit (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vrfh_if.sink  i_in,
    vrfh_if.source o_out
);
    import vrfh_pkg::*;

    localparam int unsigned NUM_W = COORD_W + 1;    // dist plus steps, < 2^13
    localparam int unsigned PROD_W = 2 * NUM_W;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_READ  = 7'b0001000,
        S_TEST  = 7'b0010000,
        S_STEP  = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic r_map [CELL_COUNT];
    logic r_rd_bit;
    logic [INDEX_W-1:0] r_clr_idx;

    t_in_item  r_item;
    t_out_item r_acc;
    t_out_item r_res;
    logic      r_out_valid;

    logic [GRID_BITS-1:0] r_cell [3];
    logic [GRID_BITS-1:0] r_last [3];
    logic                 r_dir_up [3];
    logic                 r_fin [3];
    logic [NUM_W-1:0]     r_num [3];
    logic [COORD_W-1:0]   r_den [3];
    logic [2:0]           r_face;
    logic                 r_le01, r_le02, r_le12;

    logic [COORD_W-1:0] s_coord [3];
    logic [COORD_W-1:0] e_coord [3];
    logic               take;
    logic [INDEX_W-1:0] rd_addr;
    logic [1:0]         step_k;
    logic               step_stop;
    logic               out_load;

    assign s_coord[0] = r_item.start_x;
    assign s_coord[1] = r_item.start_y;
    assign s_coord[2] = r_item.start_z;
    assign e_coord[0] = r_item.end_x;
    assign e_coord[1] = r_item.end_y;
    assign e_coord[2] = r_item.end_z;

    assign i_in.ready  = (r_state == S_IDLE);
    assign take        = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_res;
    assign rd_addr     = {r_cell[2], r_cell[1], r_cell[0]};
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // a <= b on crossing times, infinite never wins against a finite time
    function automatic logic time_le(input logic fa, input logic fb,
                                     input logic [PROD_W-1:0] pa,
                                     input logic [PROD_W-1:0] pb);
        logic res;
        if (!fa) res = !fb;
        else if (!fb) res = 1'b1;
        else res = (pa <= pb);
        return res;
    endfunction

    // Cross products registered before the comparison.
    logic [PROD_W-1:0] r_p01, r_p10, r_p02, r_p20, r_p12, r_p21;

    always_ff @(posedge i_clk) begin
        r_p01 <= PROD_W'(r_num[0]) * PROD_W'(r_den[1]);
        r_p10 <= PROD_W'(r_num[1]) * PROD_W'(r_den[0]);
        r_p02 <= PROD_W'(r_num[0]) * PROD_W'(r_den[2]);
        r_p20 <= PROD_W'(r_num[2]) * PROD_W'(r_den[0]);
        r_p12 <= PROD_W'(r_num[1]) * PROD_W'(r_den[2]);
        r_p21 <= PROD_W'(r_num[2]) * PROD_W'(r_den[1]);
    end

    // Axis to step: smallest crossing time, ties go to x, then y.
    always_comb begin
        if (r_le01 && r_le02) step_k = 2'd0;
        else if (r_le12)      step_k = 2'd1;
        else                  step_k = 2'd2;
        step_stop = (r_cell[step_k] == r_last[step_k]) || !r_fin[step_k];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr_idx) n_state = S_IDLE;
            S_IDLE:  if (take) n_state = S_SETUP;
            S_SETUP: n_state = (r_item.cmd == CMD_CAST) ? S_READ : S_OUT;
            S_READ:  n_state = S_TEST;
            S_TEST:  n_state = r_rd_bit ? S_OUT : S_STEP;
            S_STEP:  n_state = step_stop ? S_OUT : S_READ;
            S_OUT:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Map: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_map[r_clr_idx] <= 1'b0;
        end else if (r_state == S_SETUP && r_item.cmd == CMD_WRITE) begin
            r_map[r_item.cell_index] <= r_item.cell_filled;
        end
        r_rd_bit <= r_map[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr_idx <= r_clr_idx + 1'b1;
            if (out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_item <= i_in.data;

        if (out_load) r_res <= r_acc;

        if (r_state == S_SETUP) begin
            r_acc  <= '0;
            r_face <= ENTRY_TOP;
            for (int a = 0; a < 3; a++) begin
                r_cell[a] <= s_coord[a][COORD_W-1:FRAC_BITS];
                r_last[a] <= e_coord[a][COORD_W-1:FRAC_BITS];
                if (s_coord[a] < e_coord[a]) begin
                    r_dir_up[a] <= 1'b1;
                    r_fin[a]    <= 1'b1;
                    r_den[a]    <= e_coord[a] - s_coord[a];
                    r_num[a]    <= NUM_W'(1 << FRAC_BITS)
                                   - NUM_W'(s_coord[a][FRAC_BITS-1:0]);
                end else if (s_coord[a] > e_coord[a]) begin
                    r_dir_up[a] <= 1'b0;
                    r_fin[a]    <= 1'b1;
                    r_den[a]    <= s_coord[a] - e_coord[a];
                    r_num[a]    <= NUM_W'(s_coord[a][FRAC_BITS-1:0]);
                end else begin
                    r_dir_up[a] <= 1'b0;
                    r_fin[a]    <= 1'b0;
                    r_den[a]    <= COORD_W'(1);
                    r_num[a]    <= '0;
                end
            end
        end

        if (r_state == S_TEST) begin
            r_le01 <= time_le(r_fin[0], r_fin[1], r_p01, r_p10);
            r_le02 <= time_le(r_fin[0], r_fin[2], r_p02, r_p20);
            r_le12 <= time_le(r_fin[1], r_fin[2], r_p12, r_p21);
            if (r_rd_bit) begin
                r_acc.hit        <= 1'b1;
                r_acc.hit_x      <= r_cell[0];
                r_acc.hit_y      <= r_cell[1];
                r_acc.hit_z      <= r_cell[2];
                r_acc.entry_face <= r_face;
            end
        end

        // Step the chosen axis; a miss leaves the zeroed result in place.
        if (r_state == S_STEP && !step_stop) begin
            r_num[step_k]  <= r_num[step_k] + NUM_W'(1 << FRAC_BITS);
            r_cell[step_k] <= r_dir_up[step_k] ? r_cell[step_k] + 1'b1
                                               : r_cell[step_k] - 1'b1;
            unique case (step_k)
                2'd0:    r_face <= r_dir_up[0] ? ENTRY_LEFT   : ENTRY_RIGHT;
                2'd1:    r_face <= r_dir_up[1] ? ENTRY_BOTTOM : ENTRY_TOP;
                default: r_face <= r_dir_up[2] ? ENTRY_FRONT  : ENTRY_BACK;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input accepted while busy");
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (o_out.valid && $stable(o_out.data)))
        else $error("result dropped under stall");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.hit) |-> (o_out.data.entry_face == ENTRY_TOP))
        else $error("miss carries a face");
`endif

endmodule
